// ===== hw/rtl/cpu8_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu8_pkg
// Shared types and constants of the 8-bit instruction execute unit.
// ----------------------------------------------------------------------------
package cpu8_pkg;

	// Memory access codes.
	localparam logic [1:0] MOP_NONE  = 2'd0;
	localparam logic [1:0] MOP_RDB   = 2'd1;
	localparam logic [1:0] MOP_WRB   = 2'd2;
	localparam logic [1:0] MOP_WRW   = 2'd3;

	// Flag bit positions.
	localparam int FZ = 3;
	localparam int FN = 2;
	localparam int FH = 1;
	localparam int FC = 0;

	localparam logic [7:0] OP_LAST  = 8'h39;
	localparam logic [7:0] OP_NOP   = 8'h00;
	localparam logic [7:0] OP_STOP  = 8'h10;
	localparam logic [7:0] OP_LDSP  = 8'h08;
	localparam logic [7:0] OP_JR    = 8'h18;
	localparam logic [7:0] OP_JRNZ  = 8'h20;
	localparam logic [7:0] OP_JRZ   = 8'h28;
	localparam logic [7:0] OP_JRNC  = 8'h30;

	localparam logic [7:0] DAA_LIM  = 8'h99;
	localparam logic [7:0] DAA_HI   = 8'h60;
	localparam logic [7:0] DAA_LO   = 8'h06;

	// Input transaction payload.
	typedef struct packed {
		logic [7:0] cmd;
		logic [7:0] imm_lo;
		logic [7:0] imm_hi;
		logic [7:0] mem_rdata;
	} in_item_t;

	// Architectural register file.
	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  a;
		logic [3:0]  f;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic [15:0] sp;
	} arch_t;

	// Result transaction payload.
	typedef struct packed {
		logic [15:0] next_pc;
		logic [7:0]  reg_a_out;
		logic [3:0]  flags_out;
		logic [15:0] pair_bc_out;
		logic [15:0] pair_de_out;
		logic [15:0] pair_hl_out;
		logic [15:0] stack_ptr_out;
		logic [15:0] mem_addr;
		logic [1:0]  mem_op;
		logic [15:0] mem_wdata;
		logic [4:0]  cycle_count;
		logic        illegal;
	} out_item_t;

endpackage

// ===== hw/rtl/cpu8_stream_if.sv =====
// ----------------------------------------------------------------------------
// cpu8_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface cpu8_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cpu8_instruction_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// cpu8_instruction_execute_unit_top
// Execute unit for an 8-bit accumulator core, opcodes 0x00 to 0x39.
// ----------------------------------------------------------------------------
// Usage:
// Instructions enter on the in_ch channel (opcode, immediates and the memory
// byte at the pair address the opcode reads). Each accepted transaction
// yields one result transaction on out_ch with all registers, one memory
// access, the cycle count and the illegal flag.
// The register state and the result register are written at the edge the
// instruction is accepted. One instruction per cycle is sustained while
// results are taken; the state register feeds the execute logic directly.
// The result register is a single stage: when the receiver stalls, in_ch
// ready drops only while a held result is not being taken.
// Reset clears A, flags, BC, DE, HL, SP and PC to zero and empties the
// result register.
// ----------------------------------------------------------------------------
module cpu8_instruction_execute_unit_top
	import cpu8_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	cpu8_stream_if.sink   in_ch,
	cpu8_stream_if.source out_ch
);
	arch_t     state_q, nxt;
	out_item_t res, res_q;
	logic      vld_q, take;

	cpu8_exec u_exec (.item(in_ch.data), .cur(state_q), .nxt(nxt), .res(res));

	// Accept whenever the result register is empty or being drained.
	assign in_ch.ready = !vld_q || out_ch.ready;
	assign take = in_ch.valid && in_ch.ready;
	assign out_ch.valid = vld_q;
	assign out_ch.data = res_q;

	// Architectural state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (take) state_q <= nxt;
			if (take) vld_q <= 1'b1;
			else if (out_ch.ready) vld_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take) res_q <= res;
	end

	// A held result stays put while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !out_ch.ready |=> vld_q && $stable(res_q))
		else $error("result changed while stalled");
	// State PC and SP track the delivered result.
	a_pc: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q.pc == res_q.next_pc && state_q.sp == res_q.stack_ptr_out)
		else $error("state and result diverge");
	// Illegal opcodes do no memory access.
	a_ill: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && res_q.illegal |-> res_q.mem_op == MOP_NONE)
		else $error("illegal opcode accessed memory");
endmodule

// ===== hw/rtl/cpu8_exec.sv =====
// ----------------------------------------------------------------------------
// cpu8_exec
// Combinational execute logic: computes the next architectural state and the
// result fields of one instruction from the current state.
// ----------------------------------------------------------------------------
module cpu8_exec
	import cpu8_pkg::*;
(
	input  in_item_t  item,
	input  arch_t     cur,
	output arch_t     nxt,
	output out_item_t res
);
	logic [7:0]  op, lo, hi, rd, v8, r8, corr, a;
	logic [3:0]  f;
	logic [1:0]  p, mop;
	logic [15:0] bc, de, hl, sp, maddr, wdata, pv, npc;
	logic [16:0] sum;
	logic [12:0] hsum;
	logic [2:0]  idx;
	logic [1:0]  len;
	logic [4:0]  cyc;
	logic        ill, jump, cond, dec, dc;

	always_comb begin
		op = item.cmd; lo = item.imm_lo; hi = item.imm_hi; rd = item.mem_rdata;
		a = cur.a; f = cur.f; bc = cur.bc; de = cur.de; hl = cur.hl; sp = cur.sp;
		p = op[5:4]; idx = op[5:3];
		len = 2'd1; cyc = 5'd4; mop = MOP_NONE; ill = 1'b0;
		maddr = '0; wdata = '0; jump = 1'b0; cond = 1'b0;
		v8 = '0; r8 = '0; corr = '0; dec = 1'b0; dc = 1'b0; sum = '0; hsum = '0;
		// Selected register pair.
		unique case (p)
			2'd0: pv = bc;
			2'd1: pv = de;
			2'd2: pv = hl;
			default: pv = sp;
		endcase
		if (op > OP_LAST) begin
			ill = 1'b1;
		end else begin
			unique case (op[3:0])
				4'h0, 4'h8: begin
					if (op == OP_NOP) begin
					end else if (op == OP_STOP) begin
						len = 2'd2;
					end else if (op == OP_LDSP) begin
						len = 2'd3; cyc = 5'd20; mop = MOP_WRW;
						maddr = {hi, lo}; wdata = sp;
					end else begin
						len = 2'd2; cyc = 5'd8;
						priority if (op == OP_JR) begin
							cond = 1'b1; cyc = 5'd12;
						end else if (op == OP_JRNZ) cond = !f[FZ];
						else if (op == OP_JRZ) cond = f[FZ];
						else if (op == OP_JRNC) cond = !f[FC];
						else cond = f[FC];
						if (cond) begin
							jump = 1'b1;
							if (op != OP_JR) cyc = 5'd12;
						end
					end
				end
				4'h1: begin
					len = 2'd3; cyc = 5'd12;
					unique case (p)
						2'd0: bc = {hi, lo};
						2'd1: de = {hi, lo};
						2'd2: hl = {hi, lo};
						default: sp = {hi, lo};
					endcase
				end
				4'h9: begin
					cyc = 5'd8;
					sum = {1'b0, hl} + {1'b0, pv};
					hsum = {1'b0, hl[11:0]} + {1'b0, pv[11:0]};
					f[FH] = hsum[12]; f[FC] = sum[16]; f[FN] = 1'b0;
					hl = sum[15:0];
				end
				4'h2, 4'hA: begin
					cyc = 5'd8;
					maddr = (p == 2'd0) ? bc : (p == 2'd1) ? de : hl;
					if (op[3]) begin
						mop = MOP_RDB; a = rd;
					end else begin
						mop = MOP_WRB; wdata = {8'h00, a};
					end
					if (p == 2'd2) hl = maddr + 16'd1;
					else if (p == 2'd3) hl = maddr - 16'd1;
				end
				4'h3, 4'hB: begin
					cyc = 5'd8;
					pv = op[3] ? pv - 16'd1 : pv + 16'd1;
					unique case (p)
						2'd0: bc = pv;
						2'd1: de = pv;
						2'd2: hl = pv;
						default: sp = pv;
					endcase
				end
				4'h4, 4'hC, 4'h5, 4'hD: begin
					dec = op[0];
					unique case (idx)
						3'd0: v8 = bc[15:8];
						3'd1: v8 = bc[7:0];
						3'd2: v8 = de[15:8];
						3'd3: v8 = de[7:0];
						3'd4: v8 = hl[15:8];
						3'd5: v8 = hl[7:0];
						default: v8 = rd;
					endcase
					if (dec) begin
						r8 = v8 - 8'd1; f[FH] = (v8[3:0] == 4'h0);
					end else begin
						r8 = v8 + 8'd1; f[FH] = (v8[3:0] == 4'hF);
					end
					f[FZ] = (r8 == 8'h00); f[FN] = dec;
					unique case (idx)
						3'd0: bc[15:8] = r8;
						3'd1: bc[7:0] = r8;
						3'd2: de[15:8] = r8;
						3'd3: de[7:0] = r8;
						3'd4: hl[15:8] = r8;
						3'd5: hl[7:0] = r8;
						default: begin
							cyc = 5'd12; mop = MOP_WRB; maddr = hl; wdata = {8'h00, r8};
						end
					endcase
				end
				4'h6, 4'hE: begin
					len = 2'd2; cyc = 5'd8;
					unique case (idx)
						3'd0: bc[15:8] = lo;
						3'd1: bc[7:0] = lo;
						3'd2: de[15:8] = lo;
						3'd3: de[7:0] = lo;
						3'd4: hl[15:8] = lo;
						3'd5: hl[7:0] = lo;
						default: begin
							cyc = 5'd12; mop = MOP_WRB; maddr = hl; wdata = {8'h00, lo};
						end
					endcase
				end
				4'h7: begin
					unique case (p)
						2'd0: begin
							f = {3'b000, a[7]}; a = {a[6:0], a[7]};
						end
						2'd1: begin
							a = {a[6:0], cur.f[FC]}; f = {3'b000, cur.a[7]};
						end
						2'd2: begin
							// Decimal adjust after add or subtract.
							if (f[FH] || (!f[FN] && a[3:0] > 4'd9)) corr = corr | DAA_LO;
							dc = f[FC] || (!f[FN] && a > DAA_LIM);
							if (dc) corr = corr | DAA_HI;
							a = f[FN] ? a - corr : a + corr;
							f[FC] = dc; f[FZ] = (a == 8'h00); f[FH] = 1'b0;
						end
						default: begin
							f[FC] = 1'b1; f[FN] = 1'b0; f[FH] = 1'b0;
						end
					endcase
				end
				default: begin
					unique case (p)
						2'd0: begin
							f = {3'b000, a[0]}; a = {a[0], a[7:1]};
						end
						2'd1: begin
							a = {cur.f[FC], a[7:1]}; f = {3'b000, cur.a[0]};
						end
						default: begin
							a = ~a; f[FN] = 1'b1; f[FH] = 1'b1;
						end
					endcase
				end
			endcase
		end
		npc = cur.pc + {14'd0, len};
		if (jump) npc = npc + {{8{lo[7]}}, lo};
		nxt = '{pc: npc, a: a, f: f, bc: bc, de: de, hl: hl, sp: sp};
		res = '{next_pc: npc, reg_a_out: a, flags_out: f, pair_bc_out: bc,
			pair_de_out: de, pair_hl_out: hl, stack_ptr_out: sp, mem_addr: maddr,
			mem_op: mop, mem_wdata: wdata, cycle_count: cyc, illegal: ill};
	end
endmodule

// ===== tb/sv/cpu8_instruction_execute_unit_top_test.sv =====
// ----------------------------------------------------------------------------
// cpu8_instruction_execute_unit_top_test
// Drives opcodes with random immediates and memory bytes into the execute
// unit and compares every result transaction against an instruction-level
// register model kept inside the bench. Directed rows come first, then a
// random stream weighted toward supported opcodes, with random gaps on both
// channels.
// ----------------------------------------------------------------------------
module cpu8_instruction_execute_unit_top_test;
	import cpu8_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   failed = 1'b0;

	cpu8_stream_if #(.payload_t(in_item_t))  in_ch ();
	cpu8_stream_if #(.payload_t(out_item_t)) out_ch ();

	cpu8_instruction_execute_unit_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Architectural state of the model.
	logic [7:0]  m_a;
	logic [3:0]  m_f;
	logic [7:0]  m_r [6];
	logic [15:0] m_sp;
	logic [15:0] m_pc;

	out_item_t result_q [$];

	// Directed row: instruction plus optional hand-written result.
	typedef struct {
		in_item_t  ins;
		bit        fixed;
		out_item_t res;
	} dir_row_t;

	function automatic logic [15:0] pair_get(int p);
		if (p >= 3)
			return m_sp;
		return {m_r[2*p], m_r[2*p+1]};
	endfunction

	function automatic void pair_set(int p, logic [15:0] v);
		if (p >= 3)
			m_sp = v;
		else begin
			m_r[2*p] = v[15:8];
			m_r[2*p+1] = v[7:0];
		end
	endfunction

	// Executes one instruction in the model and returns its result.
	function automatic out_item_t execute_instr(in_item_t it);
		out_item_t o;
		logic [7:0]  op, a, v, r, corr;
		logic [3:0]  f;
		logic [16:0] s;
		logic [15:0] hl, w;
		int          p, idx, len;
		bit          jump, cond, n, c;
		op = it.cmd;
		a = m_a;
		f = m_f;
		p = (op >> 4) & 3;
		len = 1;
		jump = 0;
		o = '0;
		o.cycle_count = 5'd4;
		o.mem_op = MOP_NONE;
		if (op > OP_LAST) begin
			o.illegal = 1'b1;
		end else begin
			case (op[3:0])
				4'h0, 4'h8: begin
					if (op == OP_NOP) begin
					end else if (op == OP_STOP) begin
						len = 2;
					end else if (op == OP_LDSP) begin
						len = 3;
						o.cycle_count = 5'd20;
						o.mem_op = MOP_WRW;
						o.mem_addr = {it.imm_hi, it.imm_lo};
						o.mem_wdata = m_sp;
					end else begin
						len = 2;
						o.cycle_count = 5'd8;
						if (op == OP_JR) begin
							cond = 1;
							o.cycle_count = 5'd12;
						end else if (op == OP_JRNZ)
							cond = !f[FZ];
						else if (op == OP_JRZ)
							cond = f[FZ];
						else if (op == OP_JRNC)
							cond = !f[FC];
						else
							cond = f[FC];
						if (cond) begin
							jump = 1;
							if (op != OP_JR)
								o.cycle_count += 5'd4;
						end
					end
				end
				4'h1: begin
					len = 3;
					o.cycle_count = 5'd12;
					pair_set(p, {it.imm_hi, it.imm_lo});
				end
				4'h9: begin
					hl = pair_get(2);
					w = pair_get(p);
					s = hl + w;
					o.cycle_count = 5'd8;
					f[FH] = ({1'b0, hl[11:0]} + {1'b0, w[11:0]}) > 13'hFFF;
					f[FC] = s[16];
					f[FN] = 1'b0;
					pair_set(2, s[15:0]);
				end
				4'h2, 4'hA: begin
					o.cycle_count = 5'd8;
					o.mem_addr = pair_get(p < 2 ? p : 2);
					if (op[3]) begin
						o.mem_op = MOP_RDB;
						a = it.mem_rdata;
					end else begin
						o.mem_op = MOP_WRB;
						o.mem_wdata = {8'h00, a};
					end
					if (p == 2)
						pair_set(2, o.mem_addr + 16'd1);
					else if (p == 3)
						pair_set(2, o.mem_addr - 16'd1);
				end
				4'h3: begin
					o.cycle_count = 5'd8;
					pair_set(p, pair_get(p) + 16'd1);
				end
				4'hB: begin
					o.cycle_count = 5'd8;
					pair_set(p, pair_get(p) - 16'd1);
				end
				4'h4, 4'hC, 4'h5, 4'hD: begin
					idx = op >> 3;
					v = idx < 6 ? m_r[idx] : it.mem_rdata;
					if (op[0]) begin
						r = v - 8'd1;
						f[FH] = v[3:0] == 4'h0;
					end else begin
						r = v + 8'd1;
						f[FH] = v[3:0] == 4'hF;
					end
					f[FZ] = r == 8'h00;
					f[FN] = op[0];
					if (idx < 6)
						m_r[idx] = r;
					else begin
						o.cycle_count = 5'd12;
						o.mem_op = MOP_WRB;
						o.mem_addr = pair_get(2);
						o.mem_wdata = {8'h00, r};
					end
				end
				4'h6, 4'hE: begin
					idx = op >> 3;
					len = 2;
					o.cycle_count = 5'd8;
					if (idx < 6)
						m_r[idx] = it.imm_lo;
					else begin
						o.cycle_count = 5'd12;
						o.mem_op = MOP_WRB;
						o.mem_addr = pair_get(2);
						o.mem_wdata = {8'h00, it.imm_lo};
					end
				end
				4'h7: begin
					if (p == 0) begin
						c = a[7];
						a = {a[6:0], c};
						f = {3'b000, c};
					end else if (p == 1) begin
						c = a[7];
						a = {a[6:0], f[FC]};
						f = {3'b000, c};
					end else if (p == 2) begin
						// Decimal adjust after add or subtract.
						n = f[FN];
						corr = 8'h00;
						if (f[FH] || (!n && a[3:0] > 4'd9))
							corr |= DAA_LO;
						c = f[FC] || (!n && a > DAA_LIM);
						if (c)
							corr |= DAA_HI;
						a = n ? a - corr : a + corr;
						f[FC] = c;
						f[FZ] = a == 8'h00;
						f[FH] = 1'b0;
					end else begin
						f[FC] = 1'b1;
						f[FN] = 1'b0;
						f[FH] = 1'b0;
					end
				end
				default: begin
					if (p == 0) begin
						c = a[0];
						a = {c, a[7:1]};
						f = {3'b000, c};
					end else if (p == 1) begin
						c = a[0];
						a = {f[FC], a[7:1]};
						f = {3'b000, c};
					end else begin
						a = ~a;
						f[FN] = 1'b1;
						f[FH] = 1'b1;
					end
				end
			endcase
		end
		m_pc = m_pc + 16'(len);
		if (jump)
			m_pc = m_pc + {{8{it.imm_lo[7]}}, it.imm_lo};
		m_a = a;
		m_f = f;
		o.next_pc = m_pc;
		o.reg_a_out = m_a;
		o.flags_out = m_f;
		o.pair_bc_out = pair_get(0);
		o.pair_de_out = pair_get(1);
		o.pair_hl_out = pair_get(2);
		o.stack_ptr_out = m_sp;
		return o;
	endfunction

	// Sends one instruction after a random gap and queues its result.
	task automatic send_instr(in_item_t it, bit fixed, out_item_t res);
		out_item_t pred;
		int        gap;
		gap = $urandom_range(0, 13);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pred = execute_instr(it);
		if (fixed && pred != res) begin
			$error("directed row disagrees with model for cmd %h", it.cmd);
			failed = 1'b1;
		end
		result_q.push_back(pred);
		@(negedge clk);
	endtask

	function automatic in_item_t rand_instr();
		in_item_t it;
		it.imm_lo = $urandom;
		it.imm_hi = $urandom;
		it.mem_rdata = $urandom;
		if ($urandom_range(0, 15) == 0)
			it.cmd = $urandom_range(8'h3A, 8'hFF);
		else
			it.cmd = $urandom_range(0, 8'h39);
		return it;
	endfunction

	// Stimulus.
	initial begin
		dir_row_t  rows [$];
		dir_row_t  row;
		out_item_t blank;
		in_item_t  it;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		m_a = '0;
		m_f = '0;
		m_r = '{default: '0};
		m_sp = '0;
		m_pc = '0;
		blank = '0;
		// NOP straight after reset: all zero, PC one, cycle_count field of 4.
		row.ins = '{cmd: OP_NOP, imm_lo: 8'hFF, imm_hi: 8'hFF, mem_rdata: 8'hFF};
		row.fixed = 1;
		row.res = blank;
		row.res.next_pc = 16'd1;
		row.res.cycle_count = 5'd4;
		rows.push_back(row);
		// Illegal opcode at the top of the range.
		row.ins = '{cmd: 8'hFF, imm_lo: 8'h00, imm_hi: 8'h00, mem_rdata: 8'h00};
		row.res.next_pc = 16'd2;
		row.res.illegal = 1'b1;
		rows.push_back(row);
		row.fixed = 0;
		// Remaining directed rows: extremes and special cases.
		begin
			logic [7:0] ops [] = '{8'h3A, OP_STOP, 8'h31, OP_LDSP, 8'h01, 8'h21, 8'h09,
				8'h39, 8'h15, 8'h05, 8'h34, 8'h35, 8'h2A, 8'h3A, 8'h02, 8'h36,
				8'h3E, 8'h27, 8'h2F, 8'h37, 8'h38, 8'h17, 8'h1F, 8'h18, 8'h20};
			foreach (ops[i]) begin
				row.ins.cmd = ops[i];
				row.ins.imm_lo = (i % 2) ? 8'hFF : 8'h80;
				row.ins.imm_hi = (i % 2) ? 8'hFF : 8'h00;
				row.ins.mem_rdata = (i % 3 == 0) ? 8'h00 : 8'hFF;
				rows.push_back(row);
			end
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i])
			send_instr(rows[i].ins, rows[i].fixed, rows[i].res);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Once, hold off until the pipeline has drained.
			if (i == RANDOM_ITEMS / 2) begin
				in_ch.valid <= 1'b0;
				@(negedge clk);
				while (result_q.size() != 0)
					@(negedge clk);
			end
			it = rand_instr();
			send_instr(it, 0, blank);
		end
		in_ch.valid <= 1'b0;
		while (result_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (!failed)
			$display("cpu8_instruction_execute_unit_top_test passed");
		else
			$display("cpu8_instruction_execute_unit_top_test failed");
		$finish;
	end

	// Receiver: random stalls, with unstalled stretches.
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0)
				out_ch.ready <= 1'b1;
			else begin
				gap = $urandom_range(0, 13);
				if (gap == 0)
					out_ch.ready <= 1'b1;
				else begin
					out_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
					out_ch.ready <= 1'b1;
				end
			end
			do
				@(posedge clk);
			while (!out_ch.valid);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		out_item_t got, exp_res;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (result_q.size() == 0) begin
				$error("result transaction with nothing pending");
				failed = 1'b1;
			end else begin
				exp_res = result_q.pop_front();
				if (got.next_pc !== exp_res.next_pc) begin
					$error("next_pc exp %h got %h", exp_res.next_pc, got.next_pc);
					failed = 1'b1;
				end
				if (got.reg_a_out !== exp_res.reg_a_out) begin
					$error("reg_a_out exp %h got %h", exp_res.reg_a_out, got.reg_a_out);
					failed = 1'b1;
				end
				if (got.flags_out !== exp_res.flags_out) begin
					$error("flags_out exp %h got %h", exp_res.flags_out, got.flags_out);
					failed = 1'b1;
				end
				if (got.pair_bc_out !== exp_res.pair_bc_out) begin
					$error("pair_bc_out exp %h got %h", exp_res.pair_bc_out,
						got.pair_bc_out);
					failed = 1'b1;
				end
				if (got.pair_de_out !== exp_res.pair_de_out) begin
					$error("pair_de_out exp %h got %h", exp_res.pair_de_out,
						got.pair_de_out);
					failed = 1'b1;
				end
				if (got.pair_hl_out !== exp_res.pair_hl_out) begin
					$error("pair_hl_out exp %h got %h", exp_res.pair_hl_out,
						got.pair_hl_out);
					failed = 1'b1;
				end
				if (got.stack_ptr_out !== exp_res.stack_ptr_out) begin
					$error("stack_ptr_out exp %h got %h", exp_res.stack_ptr_out,
						got.stack_ptr_out);
					failed = 1'b1;
				end
				if (got.mem_addr !== exp_res.mem_addr) begin
					$error("mem_addr exp %h got %h", exp_res.mem_addr, got.mem_addr);
					failed = 1'b1;
				end
				if (got.mem_op !== exp_res.mem_op) begin
					$error("mem_op exp %h got %h", exp_res.mem_op, got.mem_op);
					failed = 1'b1;
				end
				if (got.mem_wdata !== exp_res.mem_wdata) begin
					$error("mem_wdata exp %h got %h", exp_res.mem_wdata, got.mem_wdata);
					failed = 1'b1;
				end
				if (got.cycle_count !== exp_res.cycle_count) begin
					$error("cycle_count exp %d got %d", exp_res.cycle_count,
						got.cycle_count);
					failed = 1'b1;
				end
				if (got.illegal !== exp_res.illegal) begin
					$error("illegal exp %b got %b", exp_res.illegal, got.illegal);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#2ms;
		$display("cpu8_instruction_execute_unit_top_test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cpu8_pkg.sv
hw/rtl/cpu8_stream_if.sv
hw/rtl/cpu8_exec.sv
hw/rtl/cpu8_instruction_execute_unit_top.sv
tb/sv/cpu8_instruction_execute_unit_top_test.sv
